// File: sv/set_assoc_cache_fifo_lookup_assert.svh
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_lookup_assert.svh
// assertion macros shared by the cache lookup block
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_FIFO_LOOKUP_ASSERT_SVH
`define SET_ASSOC_CACHE_FIFO_LOOKUP_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define SAC_ASSERT_SAME(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("sac assertion failed: same-cycle check");

// condition must hold in the cycle after the trigger
`define SAC_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("sac assertion failed: next-cycle check");

`endif

// File: sv/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// shared types and constants for the set associative cache lookup
// ----------------------------------------------------------------------------
package sac_pkg;

   localparam int ADDR_W  = 32;
   localparam int CNT_W   = 32;
   localparam int LINE_OW = 6;
   localparam int CSR_IW  = 2;
   localparam int CSR_DW  = 5;

   // configuration register indexes
   localparam logic [CSR_IW-1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_SET_BITS    = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_WAY_BITS    = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic update;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic match;
      logic last;
   } sts_type;

endpackage

// File: sv/sac_ram.sv
// ----------------------------------------------------------------------------
// sac_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sac_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sac_ctrl.sv
// ----------------------------------------------------------------------------
// sac_ctrl
// sequencer: accept, scan the ways of one set, then update and report
// ----------------------------------------------------------------------------
module sac_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   output sac_pkg::cmd_type cmd,
   input  sac_pkg::sts_type sts
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.update = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.match || sts.last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.update;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/sac_dp.sv
// ----------------------------------------------------------------------------
// sac_dp
// datapath: configuration, tag and pointer memories, valid bits, counters
// ----------------------------------------------------------------------------
module sac_dp #(
   parameter int MAX_LINES = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  sac_pkg::cmd_type                   cmd,
   output sac_pkg::sts_type                   sts,
   input  logic                               csr_valid,
   input  logic [sac_pkg::CSR_IW-1:0]         csr_index,
   input  logic [sac_pkg::CSR_DW-1:0]         csr_wdata,
   input  logic [sac_pkg::ADDR_W-1:0]         req_address,
   output logic                               rsp_hit,
   output logic [sac_pkg::LINE_OW-1:0]        rsp_line_index,
   output logic                               rsp_evicted,
   output logic [sac_pkg::CNT_W-1:0]          rsp_hit_count,
   output logic [sac_pkg::CNT_W-1:0]          rsp_miss_count
);

   localparam int LAW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int GLIM = $clog2(MAX_LINES + 1) - 1;
   localparam logic [3:0] GLIM_V = 4'(GLIM);

   // configuration registers
   logic [4:0] offset_ff;
   logic [2:0] setb_ff;
   logic [2:0] wayb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= 5'd4;
         setb_ff   <= 3'd0;
         wayb_ff   <= 3'd6;
      end else if (csr_valid) begin
         unique case (csr_index)
            sac_pkg::CSR_OFFSET_BITS: offset_ff <= csr_wdata[4:0];
            sac_pkg::CSR_SET_BITS:    setb_ff   <= csr_wdata[2:0];
            sac_pkg::CSR_WAY_BITS:    wayb_ff   <= csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   // effective geometry: shrink ways first, then sets
   logic [3:0]   sum_bits;
   logic [2:0]   s_eff;
   logic [2:0]   w_eff;
   logic [LAW:0] wpow;
   logic [LAW:0] spow;
   logic [LAW-1:0] way_mask;
   logic [LAW-1:0] set_mask;

   always_comb begin
      sum_bits = {1'b0, setb_ff} + {1'b0, wayb_ff};
      priority if (sum_bits <= GLIM_V) begin
         s_eff = setb_ff;
         w_eff = wayb_ff;
      end else if ({1'b0, setb_ff} <= GLIM_V) begin
         s_eff = setb_ff;
         w_eff = 3'(GLIM_V - {1'b0, setb_ff});
      end else begin
         s_eff = 3'(GLIM_V);
         w_eff = 3'd0;
      end
      wpow     = (LAW + 1)'(1) << w_eff;
      spow     = (LAW + 1)'(1) << s_eff;
      way_mask = LAW'(wpow - (LAW + 1)'(1));
      set_mask = LAW'(spow - (LAW + 1)'(1));
   end

   // address split for the incoming item
   logic [sac_pkg::ADDR_W-1:0] block_in;
   logic [LAW-1:0]             set_in;
   logic [LAW-1:0]             base_in;

   always_comb begin
      block_in = req_address >> offset_ff;
      set_in   = block_in[LAW-1:0] & set_mask;
      base_in  = LAW'(set_in << w_eff);
   end

   // per-item registers
   logic [sac_pkg::ADDR_W-1:0] block_ff;
   logic [LAW-1:0]             set_ff;
   logic [LAW-1:0]             base_ff;
   logic [LAW-1:0]             wmask_ff;
   logic [LAW-1:0]             way_ff;
   logic                       hit_ff;
   logic                       inv_found_ff;
   logic [LAW-1:0]             inv_way_ff;
   logic                       vpv_rd_ff;

   // valid bits for lines and victim pointers
   logic [MAX_LINES-1:0] valid_ff;
   logic [MAX_LINES-1:0] vpv_ff;

   // memories
   logic                       tag_wr_en;
   logic [LAW-1:0]             tag_rd_addr;
   logic [sac_pkg::ADDR_W-1:0] tag_rd;
   logic                       vp_wr_en;
   logic [LAW-1:0]             vp_rd;
   logic [LAW-1:0]             vp_wr_data;

   // scan compare on the way whose tag is on the ram output
   logic [LAW-1:0] cur_line;
   logic           match;

   always_comb begin
      cur_line    = base_ff | way_ff;
      match       = valid_ff[cur_line] && (tag_rd == block_ff);
      sts.match   = match;
      sts.last    = (way_ff == wmask_ff);
      tag_rd_addr = cmd.load ? base_in : (base_ff | ((way_ff + LAW'(1)) & wmask_ff));
   end

   // line choice at update
   logic [LAW-1:0] vsel;
   logic [LAW-1:0] upd_line;
   logic           upd_evict;

   always_comb begin
      vsel       = (vpv_rd_ff ? vp_rd : '0) & wmask_ff;
      vp_wr_data = (vsel + LAW'(1)) & wmask_ff;
      upd_evict  = 1'b0;
      priority if (hit_ff) begin
         upd_line = base_ff | way_ff;
      end else if (inv_found_ff) begin
         upd_line = base_ff | inv_way_ff;
      end else begin
         upd_line  = base_ff | vsel;
         upd_evict = 1'b1;
      end
      tag_wr_en = cmd.update && !hit_ff;
      vp_wr_en  = cmd.update && upd_evict;
   end

   sac_ram #(
      .WIDTH (sac_pkg::ADDR_W),
      .DEPTH (MAX_LINES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (upd_line),
      .wr_data (block_ff),
      .rd_en   (cmd.load | cmd.scan),
      .rd_addr (tag_rd_addr),
      .rd_data (tag_rd)
   );

   sac_ram #(
      .WIDTH (LAW),
      .DEPTH (MAX_LINES)
   ) u_vp_ram (
      .clock   (clock),
      .wr_en   (vp_wr_en),
      .wr_addr (set_ff),
      .wr_data (vp_wr_data),
      .rd_en   (cmd.load),
      .rd_addr (set_in),
      .rd_data (vp_rd)
   );

   // item capture and way scan
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         block_ff     <= block_in;
         set_ff       <= set_in;
         base_ff      <= base_in;
         wmask_ff     <= way_mask;
         way_ff       <= '0;
         hit_ff       <= 1'b0;
         inv_found_ff <= 1'b0;
         inv_way_ff   <= '0;
         vpv_rd_ff    <= vpv_ff[set_in];
      end else if (cmd.scan) begin
         if (match) begin
            hit_ff <= 1'b1;
         end else begin
            way_ff <= way_ff + LAW'(1);
         end
         if (!valid_ff[cur_line] && !inv_found_ff) begin
            inv_found_ff <= 1'b1;
            inv_way_ff   <= way_ff;
         end
      end
   end

   // valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vpv_ff   <= '0;
      end else begin
         if (tag_wr_en) begin
            valid_ff[upd_line] <= 1'b1;
         end
         if (vp_wr_en) begin
            vpv_ff[set_ff] <= 1'b1;
         end
      end
   end

   // saturating hit and miss counters
   logic [sac_pkg::CNT_W-1:0] hits_ff;
   logic [sac_pkg::CNT_W-1:0] misses_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff   <= '0;
         misses_ff <= '0;
      end else if (cmd.update) begin
         if (hit_ff) begin
            if (hits_ff != '1) begin
               hits_ff <= hits_ff + sac_pkg::CNT_W'(1);
            end
         end else if (misses_ff != '1) begin
            misses_ff <= misses_ff + sac_pkg::CNT_W'(1);
         end
      end
   end

   // result registers
   logic                          rsp_hit_ff;
   logic [sac_pkg::LINE_OW-1:0]   rsp_line_ff;
   logic                          rsp_evicted_ff;
   logic [LAW+sac_pkg::LINE_OW-1:0] line_wide;

   assign line_wide = (LAW + sac_pkg::LINE_OW)'(upd_line);

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_hit_ff     <= hit_ff;
         rsp_line_ff    <= line_wide[sac_pkg::LINE_OW-1:0];
         rsp_evicted_ff <= upd_evict;
      end
   end

   assign rsp_hit        = rsp_hit_ff;
   assign rsp_line_index = rsp_line_ff;
   assign rsp_evicted    = rsp_evicted_ff;
   assign rsp_hit_count  = hits_ff;
   assign rsp_miss_count = misses_ff;

endmodule

// File: sv/set_assoc_cache_fifo_lookup.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_lookup
// set associative cache lookup with fifo (round-robin) replacement
// ----------------------------------------------------------------------------
// usage:
//   an item (req_address) is taken when start is high and busy is low. the
//   line offset is dropped, the low block bits pick a set, and the set's ways
//   are checked one per cycle out of the tag ram, stopping at the first hit.
//   a miss fills the lowest invalid way, else the way under the set's victim
//   pointer, which then advances.
//   steps: an accept cycle, a scan of the ways checked (1 up to the
//   effective ways per set, max MAX_LINES), then an update cycle; the result
//   strobe rsp_valid shows for one cycle after that, and a new item can be
//   taken in that same cycle.
//   the result strobe is high for one cycle only; the receiver cannot stall it.
//   csr writes (csr_valid, always ready) set offset_bits, set_bits, way_bits;
//   the user makes them while busy is low, the block does not enforce it.
//   reset: registers to 4 / 0 / 6, all lines invalid, victim pointers and
//   counts zero, all at once with no clearing pass.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_lookup #(
   parameter int MAX_LINES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [sac_pkg::ADDR_W-1:0]   req_address,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   output logic [sac_pkg::LINE_OW-1:0]  rsp_line_index,
   output logic                         rsp_evicted,
   output logic [sac_pkg::CNT_W-1:0]    rsp_hit_count,
   output logic [sac_pkg::CNT_W-1:0]    rsp_miss_count,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [sac_pkg::CSR_IW-1:0]   csr_index,
   input  logic [sac_pkg::CSR_DW-1:0]   csr_wdata
);

   sac_pkg::cmd_type cmd;
   sac_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   // sequencer
   sac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath
   sac_dp #(
      .MAX_LINES (MAX_LINES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_address    (req_address),
      .rsp_hit        (rsp_hit),
      .rsp_line_index (rsp_line_index),
      .rsp_evicted    (rsp_evicted),
      .rsp_hit_count  (rsp_hit_count),
      .rsp_miss_count (rsp_miss_count)
   );

   // checks
`include "set_assoc_cache_fifo_lookup_assert.svh"

   `SAC_ASSERT_SAME(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   `SAC_ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy && !rsp_valid)
   `SAC_ASSERT_SAME(a_hit_no_evict, clock, reset, rsp_valid && rsp_hit, !rsp_evicted)
   `SAC_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// cache lookup testbench: address stream against a behavioral cache model
// ----------------------------------------------------------------------------
// Byte addresses go in over the start/busy port. A scoreboard class keeps its
// own copy of the tags, valid bits, fifo pointers and counters. It predicts
// the result strobe for each accepted item and compares the result field by
// field. The geometry is reprogrammed over the csr port between idle phases:
// extreme, oversized and random settings, with no flush between phases.
// ----------------------------------------------------------------------------
module tb_top;
   import sac_pkg::*;

   localparam int NUM_LINES = 64;
   localparam int ADDR_ITEMS = 1950;
   localparam int POOL_MAX = 96;
   localparam int NUM_FIXED = 9;
   localparam logic [CSR_IW-1:0] CSR_SPARE = 2'd3;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // one lookup result as seen on the rsp_ ports
   typedef struct packed {
      logic                hit;
      logic [LINE_OW-1:0]  line_index;
      logic                evicted;
      logic [CNT_W-1:0]    hit_count;
      logic [CNT_W-1:0]    miss_count;
   } lookup_type;

   class lookup_scoreboard;
      logic [4:0]          offset_bits;
      logic [2:0]          set_bits;
      logic [2:0]          way_bits;
      logic [ADDR_W-1:0]   block_tag [NUM_LINES];
      bit                  line_valid [NUM_LINES];
      logic [LINE_OW-1:0]  victim_ptr [NUM_LINES];
      logic [CNT_W-1:0]    hits_total;
      logic [CNT_W-1:0]    misses_total;
      lookup_type          pending_lookups [$];
      int                  errors;
      int                  accesses;
      int                  hit_results;
      int                  evictions;

      function new();
         offset_bits = 5'd4;
         set_bits = 3'd0;
         way_bits = 3'd6;
         for (int i = 0; i < NUM_LINES; i++) begin
            block_tag[i] = '0;
            line_valid[i] = 1'b0;
            victim_ptr[i] = '0;
         end
         hits_total = '0;
         misses_total = '0;
         errors = 0;
         accesses = 0;
         hit_results = 0;
         evictions = 0;
      endfunction

      // register write; the spare index changes nothing
      function void apply_csr(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] data);
         case (idx)
            CSR_OFFSET_BITS: offset_bits = data;
            CSR_SET_BITS:    set_bits = data[2:0];
            CSR_WAY_BITS:    way_bits = data[2:0];
            default: ;
         endcase
      endfunction

      function int pending_count();
         return pending_lookups.size();
      endfunction

      // predict the result of one accepted item and update the cache copy
      function void note_access(logic [ADDR_W-1:0] addr);
         logic [ADDR_W-1:0] block;
         int sb, wb, ways, set_idx, base, line, v;
         lookup_type r;
         block = addr >> offset_bits;
         sb = set_bits;
         wb = way_bits;
         // oversized geometry gives up ways first, then sets
         while (sb + wb > LINE_OW) begin
            if (wb > 0) wb--;
            else sb--;
         end
         ways = 1 << wb;
         set_idx = int'(block[5:0]) & ((1 << sb) - 1);
         base = set_idx * ways;
         r = '0;
         line = -1;
         for (int w = 0; w < ways; w++)
            if (line < 0 && line_valid[base + w] && block_tag[base + w] == block)
               line = base + w;
         if (line >= 0) begin
            r.hit = 1'b1;
            hit_results++;
            if (hits_total != CNT_MAX) hits_total++;
         end else begin
            // lowest invalid way first
            for (int w = 0; w < ways; w++)
               if (line < 0 && !line_valid[base + w]) line = base + w;
            // set full: fifo victim, pointer taken modulo the current ways
            if (line < 0) begin
               v = int'(victim_ptr[set_idx]) % ways;
               line = base + v;
               victim_ptr[set_idx] = LINE_OW'((v + 1) % ways);
               r.evicted = 1'b1;
               evictions++;
            end
            block_tag[line] = block;
            line_valid[line] = 1'b1;
            if (misses_total != CNT_MAX) misses_total++;
         end
         r.line_index = LINE_OW'(line);
         r.hit_count = hits_total;
         r.miss_count = misses_total;
         pending_lookups.insert(pending_lookups.size(), r);
         accesses++;
      endfunction

      // compare one result strobe with the oldest prediction
      function void check_lookup(logic hit, logic [LINE_OW-1:0] line_index, logic evicted,
                                 logic [CNT_W-1:0] hit_count, logic [CNT_W-1:0] miss_count);
         lookup_type e;
         if (pending_lookups.size() == 0) begin
            $error("lookup result with no item pending");
            errors++;
            return;
         end
         e = pending_lookups.pop_front();
         if (hit !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, hit);
            errors++;
         end
         if (line_index !== e.line_index) begin
            $error("line_index: expected %0d, got %0d", e.line_index, line_index);
            errors++;
         end
         if (evicted !== e.evicted) begin
            $error("evicted: expected %0d, got %0d", e.evicted, evicted);
            errors++;
         end
         if (hit_count !== e.hit_count) begin
            $error("hit_count: expected %0d, got %0d", e.hit_count, hit_count);
            errors++;
         end
         if (miss_count !== e.miss_count) begin
            $error("miss_count: expected %0d, got %0d", e.miss_count, miss_count);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [ADDR_W-1:0]    req_address = '0;
   logic                 rsp_valid;
   logic                 rsp_hit;
   logic [LINE_OW-1:0]   rsp_line_index;
   logic                 rsp_evicted;
   logic [CNT_W-1:0]     rsp_hit_count;
   logic [CNT_W-1:0]     rsp_miss_count;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IW-1:0]    csr_index = '0;
   logic [CSR_DW-1:0]    csr_wdata = '0;

   lookup_scoreboard     lookups;
   logic [ADDR_W-1:0]    addr_pool [POOL_MAX];
   int                   geometries = 0;

   set_assoc_cache_fifo_lookup dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_address    (req_address),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .rsp_line_index (rsp_line_index),
      .rsp_evicted    (rsp_evicted),
      .rsp_hit_count  (rsp_hit_count),
      .rsp_miss_count (rsp_miss_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #4_000_000;
      $error("run did not finish in time");
      $display("*** FAILED ***");
      $finish;
   end

   // result monitor, values taken as they stood before the edge
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         lookups.check_lookup(rsp_hit, rsp_line_index, rsp_evicted,
                              rsp_hit_count, rsp_miss_count);
   end

   // present one address and hold it until the block takes the item
   task automatic send_access(input logic [ADDR_W-1:0] addr);
      start <= 1'b1;
      req_address <= addr;
      do @(posedge clock); while (busy !== 1'b0);
      lookups.note_access(addr);
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // hold off until every predicted result has come back
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (lookups.pending_count() != 0) @(posedge clock);
   endtask

   // keeps csr_valid high; the caller lowers it after the last write
   task automatic write_csr(input logic [CSR_IW-1:0] idx, input logic [CSR_DW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      lookups.apply_csr(idx, data);
   endtask

   // reprogram all three registers with the block idle; unused data bits random
   task automatic program_geometry(input int off, input int sets_log, input int ways_log);
      wait_drained();
      repeat (4) @(posedge clock);
      write_csr(CSR_OFFSET_BITS, CSR_DW'(off));
      write_csr(CSR_SET_BITS, {2'($urandom), 3'(sets_log)});
      write_csr(CSR_WAY_BITS, {2'($urandom), 3'(ways_log)});
      if (geometries == 0 || $urandom_range(0, 3) == 0)
         write_csr(CSR_SPARE, CSR_DW'($urandom));
      csr_valid <= 1'b0;
      geometries++;
   endtask

   // stimulus
   initial begin
      int fixed_off [NUM_FIXED];
      int fixed_sets [NUM_FIXED];
      int fixed_ways [NUM_FIXED];
      int phase;
      int pool_size;
      int n_items;
      int burst;
      int roll;
      int pick;
      bit steady;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] addr;

      fixed_off = '{0, 31, 0, 31, 5, 2, 3, 1, 4};
      fixed_sets = '{0, 6, 6, 0, 3, 7, 2, 5, 0};
      fixed_ways = '{0, 0, 0, 6, 3, 7, 7, 4, 6};
      lookups = new();
      phase = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: fully associative, 64 ways, 16-byte lines
      send_access(32'h0000_0000);
      send_access(32'hFFFF_FFFF);
      send_access(32'h0000_000F);
      send_access(32'hFFFF_FFF0);
      send_access(32'h0000_0010);

      // geometry change: lines kept, set of two ways already full
      program_geometry(4, 0, 1);
      send_access(32'h0000_0010);
      send_access(32'h0000_0020);
      send_access(32'h0000_0010);
      send_access(32'h0000_0030);

      // oversized geometry shrinks to 64 sets of one way
      program_geometry(0, 7, 7);
      send_access(32'h0000_0005);
      send_access(32'h0000_0045);
      send_access(32'h0000_0045);
      send_access(32'h8000_003F);

      // widest line: only blocks zero and one exist
      program_geometry(31, 6, 0);
      send_access(32'h7FFF_FFFF);
      send_access(32'h8000_0000);
      send_access(32'h0000_0000);
      send_access(32'hFFFF_FFFF);

      // byte lines, four sets of sixteen ways
      program_geometry(0, 2, 4);
      send_access(32'hAAAA_AAAA);
      send_access(32'h5555_5555);
      send_access(32'hAAAA_AAAA);

      // random phases: extreme geometries first, then random ones
      while (lookups.accesses < ADDR_ITEMS) begin
         if (phase < NUM_FIXED)
            program_geometry(fixed_off[phase], fixed_sets[phase], fixed_ways[phase]);
         else if ($urandom_range(0, 1) == 0)
            program_geometry($urandom_range(0, 31), $urandom_range(0, 7), $urandom_range(0, 7));
         else
            program_geometry($urandom_range(0, 8), $urandom_range(0, 7), $urandom_range(0, 7));
         phase++;

         // working set of addresses; small pools give many hits
         pool_size = $urandom_range(4, POOL_MAX);
         for (int i = 0; i < pool_size; i++) addr_pool[i] = $urandom;
         steady = ($urandom_range(0, 3) == 0);
         n_items = $urandom_range(40, 140);
         mask = ADDR_W'((64'd1 << lookups.offset_bits) - 64'd1);

         while (n_items > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && n_items > 0) begin
               pick = $urandom_range(0, pool_size - 1);
               roll = $urandom_range(0, 99);
               if (roll < 70) begin
                  // known block, new byte within its line
                  addr = (addr_pool[pick] & ~mask) | (ADDR_W'($urandom) & mask);
               end else if (roll < 90) begin
                  // new block in the same set as a known one
                  addr = addr_pool[pick] ^
                         ADDR_W'(64'($urandom) << (lookups.offset_bits + 6));
                  addr_pool[pick] = addr;
               end else begin
                  addr = $urandom;
                  addr_pool[pick] = addr;
               end
               send_access(addr);
               burst--;
               n_items--;
            end
            // gaps between bursts, now and then a full drain
            if (!steady) begin
               if ($urandom_range(0, 19) == 0) wait_drained();
               else pause_sender($urandom_range(1, 8));
            end
         end
      end

      // drain and let the last strobe settle
      wait_drained();
      repeat (16) @(posedge clock);

      $display("covered %0d lookups: %0d hits, %0d misses, %0d fifo evictions",
               lookups.accesses, lookups.hit_results,
               lookups.accesses - lookups.hit_results, lookups.evictions);
      $display("across %0d geometries, oversized and fully associative ones included",
               geometries);
      if (lookups.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/sac_pkg.sv
sv/sac_ram.sv
sv/sac_ctrl.sv
sv/sac_dp.sv
sv/set_assoc_cache_fifo_lookup.sv
dv/tb_top.sv
